[rtl/tdfr_pkg.sv]
// tdfr_pkg: types and constants for the tally display frame receiver
// no dependencies; used by the interfaces, the parser and the top level

package tdfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned TallyW   = 4;
  localparam int unsigned BrightW  = 2;
  localparam int unsigned TextLen  = 16;
  localparam int unsigned HalfLen  = TextLen / 2;
  localparam int unsigned TextIdxW = $clog2(TextLen);
  localparam int unsigned WordW    = HalfLen * ByteW;

  // command codes on the input channel
  localparam logic CmdByte  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // bit positions inside the received bytes
  localparam int unsigned StartBit   = 7;
  localparam int unsigned TallyLsb   = 0;
  localparam int unsigned BrightLsb  = 4;

  localparam logic [TextIdxW-1:0] LastTextIdx = TextIdxW'(TextLen - 1);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhControl = 2'd1,
    PhText    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [AddrW-1:0]   address;
    logic [TallyW-1:0]  tally;
    logic [BrightW-1:0] brightness;
    logic [WordW-1:0]   text_first;
    logic [WordW-1:0]   text_second;
  } frame_t;

endpackage

[rtl/tdfr_if.sv]
// tdfr_in_if / tdfr_out_if: valid-ready channels of the frame receiver
// depends on tdfr_pkg for field widths

interface tdfr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [tdfr_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface tdfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [tdfr_pkg::AddrW-1:0]    address;
  logic [tdfr_pkg::TallyW-1:0]   tally;
  logic [tdfr_pkg::BrightW-1:0]  brightness;
  logic [tdfr_pkg::WordW-1:0]    text_first;
  logic [tdfr_pkg::WordW-1:0]    text_second;

  modport source (output valid, output address, output tally, output brightness,
                  output text_first, output text_second, input ready);
  modport sink   (input valid, input address, input tally, input brightness,
                  input text_first, input text_second, output ready);
endinterface

[rtl/tdfr_parser.sv]
// tdfr_parser: frame state machine and text store for the frame receiver
// depends on tdfr_pkg; one accepted beat is parsed per cycle

module tdfr_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       beat_i,
  input  logic                       cmd_i,
  input  logic [tdfr_pkg::ByteW-1:0] rx_byte_i,
  output logic                       res_valid_o,
  output tdfr_pkg::frame_t           res_o
);

  tdfr_pkg::phase_e                   phase_q, phase_d;
  logic [tdfr_pkg::TextIdxW-1:0]      count_q, count_d;
  logic [tdfr_pkg::AddrW-1:0]         addr_q, addr_d;
  logic [tdfr_pkg::CharW-1:0]         ctrl_q, ctrl_d;
  logic [tdfr_pkg::CharW-1:0]         store_q [tdfr_pkg::TextLen];
  logic                               wr_en;
  logic [tdfr_pkg::CharW-1:0]         chars [tdfr_pkg::TextLen];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tdfr_pkg::PhIdle;
      count_q <= '0;
      addr_q  <= '0;
      ctrl_q  <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      ctrl_q  <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[count_q] <= rx_byte_i[tdfr_pkg::CharW-1:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    addr_d      = addr_q;
    ctrl_d      = ctrl_q;
    wr_en       = 1'b0;
    res_valid_o = 1'b0;
    if (beat_i) begin
      priority if (cmd_i == tdfr_pkg::CmdFlush) begin
        phase_d = tdfr_pkg::PhIdle;
      end else if (rx_byte_i[tdfr_pkg::StartBit]) begin
        // a start byte always opens a new frame
        addr_d  = rx_byte_i[tdfr_pkg::AddrW-1:0];
        phase_d = tdfr_pkg::PhControl;
      end else begin
        unique case (phase_q)
          tdfr_pkg::PhControl: begin
            ctrl_d  = rx_byte_i[tdfr_pkg::CharW-1:0];
            count_d = '0;
            phase_d = tdfr_pkg::PhText;
          end
          tdfr_pkg::PhText: begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
            if (count_q == tdfr_pkg::LastTextIdx) begin
              phase_d     = tdfr_pkg::PhIdle;
              res_valid_o = 1'b1;
            end
          end
          default: begin
            phase_d = tdfr_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  // last character bypasses the store, it is written in this same cycle
  always_comb begin
    for (int i = 0; i < tdfr_pkg::TextLen; i++) begin
      chars[i] = (wr_en && (count_q == tdfr_pkg::TextIdxW'(i)))
               ? rx_byte_i[tdfr_pkg::CharW-1:0] : store_q[i];
    end
  end

  always_comb begin
    res_o.address    = addr_q;
    res_o.tally      = ctrl_q[tdfr_pkg::TallyLsb +: tdfr_pkg::TallyW];
    res_o.brightness = ctrl_q[tdfr_pkg::BrightLsb +: tdfr_pkg::BrightW];
    for (int k = 0; k < tdfr_pkg::HalfLen; k++) begin
      res_o.text_first[k*tdfr_pkg::ByteW +: tdfr_pkg::ByteW]  = {1'b0, chars[k]};
      res_o.text_second[k*tdfr_pkg::ByteW +: tdfr_pkg::ByteW] =
        {1'b0, chars[k + tdfr_pkg::HalfLen]};
    end
  end

  a_res_only_on_last_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (phase_q == tdfr_pkg::PhText) && (count_q == tdfr_pkg::LastTextIdx))
    else $error("result raised outside the last text byte");

  a_res_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == tdfr_pkg::PhIdle)
    else $error("parser not idle after a complete frame");

  a_flush_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && cmd_i == tdfr_pkg::CmdFlush) |=> phase_q == tdfr_pkg::PhIdle)
    else $error("parser not idle after flush");

  a_start_opens_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat_i && cmd_i == tdfr_pkg::CmdByte && rx_byte_i[tdfr_pkg::StartBit])
    |=> (phase_q == tdfr_pkg::PhControl) && (addr_q == $past(rx_byte_i[tdfr_pkg::AddrW-1:0])))
    else $error("start byte did not open a frame");

  a_text_count_zero_on_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(phase_q) == tdfr_pkg::PhControl && phase_q == tdfr_pkg::PhText) |-> count_q == '0)
    else $error("text count not cleared at frame start");

endmodule

[rtl/tally_display_frame_receiver.sv]
// tally_display_frame_receiver: top level of the tally display frame receiver
// depends on tdfr_pkg, tdfr_in_if, tdfr_out_if and tdfr_parser
//
// Usage:
//   in_i carries one beat per received byte (cmd = byte) or a flush
//   (cmd = flush, rx_byte ignored). A byte with bit 7 set starts a frame,
//   the next byte is control, then sixteen text bytes; the sixteenth text
//   byte produces one beat on out_o with address, tally, brightness and text.
//   The result beat is valid on out_o in the cycle after the last
//   text byte is accepted. Throughput: one input beat per cycle while
//   in_i.ready is high; the parser state machine steps on each accepted byte.
//   out_o is held in a single output register. While it holds a result that
//   is not taken, in_i.ready is low; ready is high whenever that register is
//   empty or being taken in the same cycle.
//   Reset puts the parser in idle, discards any partial frame and empties
//   the output register. The text store is not cleared; each entry is
//   written in a frame before that frame reads it.

module tally_display_frame_receiver (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdfr_in_if.sink          in_i,
  tdfr_out_if.source       out_o
);

  logic              beat;
  logic              res_valid;
  tdfr_pkg::frame_t  res;
  logic              out_valid_q, out_valid_d;
  tdfr_pkg::frame_t  out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign beat       = in_i.valid && in_i.ready;

  tdfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .cmd_i       (in_i.cmd),
    .rx_byte_i   (in_i.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.address     = out_q.address;
  assign out_o.tally       = out_q.tally;
  assign out_o.brightness  = out_q.brightness;
  assign out_o.text_first  = out_q.text_first;
  assign out_o.text_second = out_q.text_second;

endmodule
